// ----- rtl/zrbm_pkg.sv -----
`timescale 1ns / 1ps

package zrbm_pkg;

   localparam int ADDR_W = 22;
   localparam int LEN_W = 23;
   localparam int NZ_W = 15;
   localparam int HASH_W = 64;
   localparam int BANK_W = 3;
   localparam int PAGE_W = 8;
   localparam int MINRUN_W = 15;
   localparam int BLK_W = 16;
   localparam int CSR_W = 16;
   localparam int CSR_IDX_W = 2;
   localparam int RESULTS_MAX = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int PAGE_BYTES_DEFAULT = 16384;

   localparam logic [HASH_W-1:0] HASH_BASIS = 64'hcbf29ce484222325;
   localparam logic [8:0] HASH_PRIME_LOW = 9'h1B3;
   localparam int HASH_PRIME_SHIFT = 40;
   localparam logic [LEN_W-1:0] LEN_MAX = 23'h7FFFFF;
   localparam logic [BANK_W-1:0] BANK_NONE = 3'd4;
   localparam logic [MINRUN_W-1:0] MIN_RUN_RESET = 15'd16;
   localparam logic [BLK_W-1:0] MAX_BLOCKS_RESET = 16'd64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_RUN    = 2'd0,
      CSR_MAX_BLOCKS = 2'd1,
      CSR_MERGE_ZERO = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0]        data_byte;
      logic [ADDR_W-1:0] region_base;
      logic [BANK_W-1:0] region_bank;
      logic [PAGE_W-1:0] region_page;
      logic              region_is_rom;
      logic              region_end;
      logic              scan_end;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] block_address;
      logic [LEN_W-1:0]  block_length;
      logic              is_zero_fill;
      logic [NZ_W-1:0]   nonzero_count;
      logic [HASH_W-1:0] block_hash;
      logic [BANK_W-1:0] block_bank;
      logic [PAGE_W-1:0] block_page;
      logic              block_is_rom;
      logic [PAGE_W-1:0] end_page;
      logic              truncated;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]                  count;
      rsp_type [RESULTS_MAX-1:0]   item;
   } bundle_type;

   typedef struct packed {
      logic                         full;
      logic [$clog2(QUEUE_DEPTH):0] level;
   } queue_stat_type;

endpackage

// ----- rtl/zrbm_front.sv -----
`timescale 1ns / 1ps

module zrbm_front import zrbm_pkg::*; #(
   parameter int PAGE_BYTES = PAGE_BYTES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data,
   input  logic                 req_accept,
   input  req_type              req_data,
   output logic                 bundle_valid,
   output bundle_type           bundle
);

   localparam int OFF_W = $clog2(PAGE_BYTES);
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(PAGE_BYTES - 1);
   localparam logic [LEN_W-1:0] PAGE_LEN = LEN_W'(PAGE_BYTES);

   typedef struct packed {
      logic [BLK_W-1:0]  emitted;
      logic              ovf;
      logic              pv;
      logic [ADDR_W:0]   pa;
      logic [LEN_W-1:0]  pl;
      logic [BANK_W-1:0] pb;
      logic [PAGE_W-1:0] pp;
      logic              pr;
   } scan_type;

   typedef struct packed {
      scan_type                  st;
      logic [1:0]                n;
      rsp_type [RESULTS_MAX-1:0] res;
   } work_type;

   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [BANK_W-1:0] bank;
      logic [PAGE_W-1:0] page;
      logic              rom;
      logic [BLK_W-1:0]  budget;
      logic              merge;
   } ctx_type;

   function automatic logic [HASH_W-1:0] hash_mul(input logic [HASH_W-1:0] x);
      return (x << HASH_PRIME_SHIFT) + (x * HASH_PRIME_LOW);
   endfunction

   function automatic rsp_type make_rsp(
      input logic [ADDR_W:0] addr, input logic [LEN_W-1:0] len, input logic zero,
      input logic [NZ_W-1:0] nz, input logic [HASH_W-1:0] hash,
      input logic [BANK_W-1:0] bank, input logic [PAGE_W-1:0] page,
      input logic rom, input logic trunc);
      rsp_type r;
      logic [LEN_W:0] lastb;
      logic [LEN_W:0] shifted;
      lastb = {1'b0, len} + (LEN_W+1)'(addr) - (LEN_W+1)'(1);
      shifted = lastb >> PAGE_SHIFT;
      r.block_address = addr[ADDR_W-1:0];
      r.block_length = len;
      r.is_zero_fill = zero;
      r.nonzero_count = nz;
      r.block_hash = hash;
      r.block_bank = bank;
      r.block_page = page;
      r.block_is_rom = rom;
      r.end_page = trunc ? '0 : ((len > PAGE_LEN) ? shifted[PAGE_W-1:0] : page);
      r.truncated = trunc;
      r.last = 1'b0;
      return r;
   endfunction

   function automatic work_type put(input work_type w, input rsp_type r);
      if (w.n != 2'd3) begin
         w.res[w.n] = r;
         w.n = w.n + 2'd1;
      end
      return w;
   endfunction

   function automatic work_type flush(input work_type w);
      if (w.st.pv) begin
         w = put(w, make_rsp(w.st.pa, w.st.pl, 1'b1, '0, '0, w.st.pb, w.st.pp, w.st.pr, 1'b0));
      end
      w.st.pv = 1'b0;
      return w;
   endfunction

   function automatic work_type overflow(input work_type w);
      w.st.ovf = 1'b1;
      w = flush(w);
      w = put(w, make_rsp('0, '0, 1'b0, '0, '0, BANK_NONE, '0, 1'b0, 1'b1));
      return w;
   endfunction

   function automatic work_type emit_data(
      input work_type w, input ctx_type c, input logic [OFF_W-1:0] start,
      input logic [LEN_W-1:0] len, input logic [NZ_W-1:0] nz, input logic [HASH_W-1:0] hash);
      if (w.st.emitted >= c.budget) begin
         w = overflow(w);
      end else begin
         w = flush(w);
         w.st.emitted = w.st.emitted + BLK_W'(1);
         w = put(w, make_rsp({1'b0, c.base} + (ADDR_W+1)'(start), len, 1'b0, nz, hash,
                             c.bank, c.page, c.rom, 1'b0));
      end
      return w;
   endfunction

   function automatic work_type emit_zero(
      input work_type w, input ctx_type c, input logic [OFF_W-1:0] start,
      input logic [LEN_W-1:0] len);
      logic [ADDR_W:0]   addr;
      logic [LEN_W:0]    sum;
      addr = {1'b0, c.base} + (ADDR_W+1)'(start);
      sum = {1'b0, w.st.pl} + {1'b0, len};
      if (w.st.emitted >= c.budget) begin
         w = overflow(w);
      end else if (c.merge) begin
         if (w.st.pv && (({1'b0, w.st.pl} + (LEN_W+1)'(w.st.pa)) == (LEN_W+1)'(addr))) begin
            w.st.pl = sum[LEN_W] ? LEN_MAX : sum[LEN_W-1:0];
         end else begin
            w = flush(w);
            w.st.pv = 1'b1;
            w.st.pa = addr;
            w.st.pl = len;
            w.st.pb = c.bank;
            w.st.pp = c.page;
            w.st.pr = c.rom;
            w.st.emitted = w.st.emitted + BLK_W'(1);
         end
      end else begin
         w.st.emitted = w.st.emitted + BLK_W'(1);
         w = put(w, make_rsp(addr, len, 1'b1, '0, '0, c.bank, c.page, c.rom, 1'b0));
      end
      return w;
   endfunction

   logic [MINRUN_W-1:0] min_run_ff;
   logic [BLK_W-1:0]    max_blocks_ff;
   logic                merge_zero_ff;

   scan_type            st_ff, st_in;
   logic [OFF_W-1:0]    byte_offset_ff, byte_offset_in;
   logic                data_open_ff, data_open_in;
   logic [OFF_W-1:0]    data_start_ff, data_start_in;
   logic [OFF_W:0]      data_nz_ff, data_nz_in;
   logic                zr_active_ff, zr_active_in;
   logic [OFF_W-1:0]    zr_start_ff, zr_start_in;
   logic [HASH_W-1:0]   hash_ff, hash_in;
   logic [HASH_W-1:0]   hbz_ff, hbz_in;

   work_type            w;

   always_comb begin
      ctx_type           c;
      logic [LEN_W-1:0]  mr;
      logic [LEN_W-1:0]  zlen;
      logic [LEN_W-1:0]  size;
      logic [LEN_W-1:0]  tail;
      logic              nonzero;
      logic              long_lead;
      logic              short_lead;
      logic              long_tail;
      logic              reg_end;
      logic [HASH_W-1:0] prod;
      logic [OFF_W-1:0]  off;

      c.base = req_data.region_base;
      c.bank = req_data.region_bank;
      c.page = req_data.region_page;
      c.rom = req_data.region_is_rom;
      c.budget = (max_blocks_ff == '0) ? BLK_W'(1) : max_blocks_ff;
      c.merge = merge_zero_ff;
      mr = (min_run_ff == '0) ? LEN_W'(MIN_RUN_RESET) : LEN_W'(min_run_ff);
      off = byte_offset_ff;
      nonzero = (req_data.data_byte != 8'd0);
      reg_end = req_data.scan_end || req_data.region_end || (off >= OFF_LAST);
      zlen = LEN_W'(off) - LEN_W'(zr_start_ff);
      long_lead = zr_active_ff && nonzero && (zlen >= mr);
      prod = hash_mul((long_lead ? HASH_BASIS : hash_ff) ^ HASH_W'(req_data.data_byte));

      w.st = st_ff;
      w.n = 2'd0;
      w.res = '0;
      data_open_in = data_open_ff;
      data_start_in = data_start_ff;
      data_nz_in = data_nz_ff;
      zr_active_in = zr_active_ff;
      zr_start_in = zr_start_ff;
      hash_in = hash_ff;
      hbz_in = hbz_ff;
      short_lead = 1'b0;

      if (!w.st.ovf) begin
         if (nonzero) begin
            if (zr_active_ff) begin
               if (long_lead) begin
                  if (data_open_in) begin
                     data_open_in = 1'b0;
                     w = emit_data(w, c, data_start_in,
                                   LEN_W'(zr_start_ff) - LEN_W'(data_start_in),
                                   NZ_W'(data_nz_in), hbz_ff);
                  end
                  if (!w.st.ovf) begin
                     w = emit_zero(w, c, zr_start_ff, zlen);
                  end
               end else begin
                  short_lead = 1'b1;
               end
               zr_active_in = 1'b0;
            end
            if (!w.st.ovf) begin
               if (!data_open_in) begin
                  data_open_in = 1'b1;
                  data_start_in = short_lead ? zr_start_ff : off;
                  data_nz_in = '0;
                  w = flush(w);
               end
               data_nz_in = data_nz_in + (OFF_W+1)'(1);
               hash_in = prod;
            end
         end else begin
            if (!zr_active_ff) begin
               zr_active_in = 1'b1;
               zr_start_in = off;
               hbz_in = hash_ff;
            end
            hash_in = prod;
         end
      end

      size = LEN_W'(off) + LEN_W'(1);
      tail = size - LEN_W'(zr_start_in);
      long_tail = zr_active_in && (tail >= mr);
      byte_offset_in = off;

      if (!w.st.ovf && reg_end) begin
         if (data_open_in) begin
            if (long_tail) begin
               w = emit_data(w, c, data_start_in,
                             LEN_W'(zr_start_in) - LEN_W'(data_start_in),
                             NZ_W'(data_nz_in), hbz_in);
               if (!w.st.ovf) begin
                  w = emit_zero(w, c, zr_start_in, tail);
               end
            end else begin
               w = emit_data(w, c, data_start_in, size - LEN_W'(data_start_in),
                             NZ_W'(data_nz_in), hash_in);
            end
         end else if (zr_active_in) begin
            if (long_tail) begin
               w = emit_zero(w, c, zr_start_in, tail);
            end else begin
               w = emit_data(w, c, zr_start_in, tail, '0, hash_in);
            end
         end
         byte_offset_in = '0;
         data_open_in = 1'b0;
         data_start_in = '0;
         data_nz_in = '0;
         zr_active_in = 1'b0;
         zr_start_in = '0;
         hash_in = HASH_BASIS;
         hbz_in = HASH_BASIS;
      end else if (!w.st.ovf) begin
         byte_offset_in = off + OFF_W'(1);
      end

      if (req_data.scan_end) begin
         if (!w.st.ovf) begin
            w = flush(w);
         end
         w.st = '0;
         byte_offset_in = '0;
         data_open_in = 1'b0;
         data_start_in = '0;
         data_nz_in = '0;
         zr_active_in = 1'b0;
         zr_start_in = '0;
         hash_in = HASH_BASIS;
         hbz_in = HASH_BASIS;
      end

      if (w.n != 2'd0) begin
         w.res[w.n - 2'd1].last = 1'b1;
      end
      st_in = w.st;
   end

   assign bundle_valid = req_accept && (w.n != 2'd0);
   assign bundle.count = w.n;
   assign bundle.item = w.res;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_run_ff <= MIN_RUN_RESET;
         max_blocks_ff <= MAX_BLOCKS_RESET;
         merge_zero_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_RUN: begin
               min_run_ff <= csr_data[MINRUN_W-1:0];
            end
            CSR_MAX_BLOCKS: begin
               max_blocks_ff <= csr_data[BLK_W-1:0];
            end
            CSR_MERGE_ZERO: begin
               merge_zero_ff <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
         byte_offset_ff <= '0;
         data_open_ff <= 1'b0;
         data_start_ff <= '0;
         data_nz_ff <= '0;
         zr_active_ff <= 1'b0;
         zr_start_ff <= '0;
         hash_ff <= HASH_BASIS;
         hbz_ff <= HASH_BASIS;
      end else if (req_accept) begin
         st_ff <= st_in;
         byte_offset_ff <= byte_offset_in;
         data_open_ff <= data_open_in;
         data_start_ff <= data_start_in;
         data_nz_ff <= data_nz_in;
         zr_active_ff <= zr_active_in;
         zr_start_ff <= zr_start_in;
         hash_ff <= hash_in;
         hbz_ff <= hbz_in;
      end
   end

endmodule

// ----- rtl/zrbm_back.sv -----
`timescale 1ns / 1ps

module zrbm_back import zrbm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           bundle_valid,
   input  bundle_type     bundle,
   input  logic           pop,
   output logic           empty,
   output rsp_type        rsp_data,
   output queue_stat_type stat
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   bundle_type         mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     level_ff, level_in;
   logic [1:0]         idx_ff, idx_in;
   bundle_type         head;
   logic               pop_item;
   logic               pop_bundle;

   assign head = mem_ff[rd_ptr_ff];
   assign empty = (level_ff == '0);
   assign rsp_data = head.item[idx_ff];
   assign stat.full = (level_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign stat.level = level_ff;

   assign pop_item = pop && !empty;
   assign pop_bundle = pop_item && (idx_ff == (head.count - 2'd1));

   always_comb begin
      wr_ptr_in = bundle_valid ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_bundle ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      level_in = level_ff + (PTR_W+1)'(bundle_valid) - (PTR_W+1)'(pop_bundle);
      idx_in = idx_ff;
      if (pop_bundle) begin
         idx_in = 2'd0;
      end else if (pop_item) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (bundle_valid) begin
         mem_ff[wr_ptr_ff] <= bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff <= '0;
         idx_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff <= level_in;
         idx_ff <= idx_in;
      end
   end

endmodule

// ----- rtl/zero_run_block_mapper.sv -----
`timescale 1ns / 1ps

// one memory byte per clock: the front end folds each byte into the running block, fnv-1a
// hash and zero-run state in a single cycle and hands the up to three results that the
// byte closes to a four-entry queue as one entry; the back end drains that queue one result
// per cycle while pop is high, a result showing once its bundle is in the queue; bytes keep
// streaming at one per cycle while the queue has room; full rises when four entries wait, that
// is when bytes that close blocks arrive faster than pop drains their results. the user must
// write min_run, max_blocks and merge_zero via csr between scans; the block does not check.
module zero_run_block_mapper import zrbm_pkg::*; #(
   parameter int PAGE_BYTES = PAGE_BYTES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  req_type              req_data,
   output logic                 empty,
   input  logic                 pop,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data
);

   logic           req_accept;
   logic           bundle_valid;
   bundle_type     bundle;
   queue_stat_type stat;

   assign full = stat.full;
   assign req_accept = push && !stat.full;

   zrbm_front #(
      .PAGE_BYTES(PAGE_BYTES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_accept   (req_accept),
      .req_data     (req_data),
      .bundle_valid (bundle_valid),
      .bundle       (bundle)
   );

   zrbm_back u_back (
      .clock        (clock),
      .reset        (reset),
      .bundle_valid (bundle_valid),
      .bundle       (bundle),
      .pop          (pop),
      .empty        (empty),
      .rsp_data     (rsp_data),
      .stat         (stat)
   );

`ifndef ASSERT_OFF
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      stat.level <= ($clog2(QUEUE_DEPTH)+1)'(QUEUE_DEPTH))
      else $error("queue level beyond depth");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty)
      else $error("results present after reset");

   a_marker_shape: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.truncated) |->
      (rsp_data.block_length == '0 && !rsp_data.is_zero_fill && rsp_data.block_hash == '0))
      else $error("malformed truncation marker");

   a_zero_fill_shape: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.is_zero_fill) |->
      (rsp_data.block_hash == '0 && rsp_data.nonzero_count == '0 && !rsp_data.truncated))
      else $error("zero fill block carries data fields");
`endif

endmodule
